[design/bilinear_image_scaler_top_macros.svh]
// ----------------------------------------------------------------------------
// Bilinear image scaler assertion macros
// Concurrent property wrappers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_SCALER_TOP_MACROS_SVH
`define BILINEAR_IMAGE_SCALER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define BIS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bis assertion failed");

`define BIS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bis assertion failed");

`else

`define BIS_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define BIS_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

[design/bis_pkg.sv]
// ----------------------------------------------------------------------------
// Bilinear image scaler package
// Field widths, request and register codes, shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

    localparam int SRC_COORD_W = 8;
    localparam int PIX_W       = 8;
    localparam int DST_COORD_W = 10;
    localparam int IN_SZ_W     = 9;
    localparam int OUT_SZ_W    = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 2'd3;

    localparam logic [IN_SZ_W-1:0]  IN_SZ_RESET  = 9'd256;
    localparam logic [OUT_SZ_W-1:0] OUT_SZ_RESET = 11'd256;

    typedef struct packed {
        logic [OUT_SZ_W-1:0] out_width;
        logic [OUT_SZ_W-1:0] out_height;
    } out_size_t;

endpackage

`default_nettype wire

[design/bis_if.sv]
// ----------------------------------------------------------------------------
// Bilinear image scaler channels
// Request, response and configuration valid/ready channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface bis_req_if;
    import bis_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [SRC_COORD_W-1:0] src_row;
    logic [SRC_COORD_W-1:0] src_col;
    logic [PIX_W-1:0]       src_pixel;
    logic [DST_COORD_W-1:0] dst_row;
    logic [DST_COORD_W-1:0] dst_col;

    modport source (
        output valid, req_type, src_row, src_col, src_pixel, dst_row, dst_col,
        input  ready
    );
    modport sink (
        input  valid, req_type, src_row, src_col, src_pixel, dst_row, dst_col,
        output ready
    );
endinterface

interface bis_rsp_if;
    import bis_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] dst_pixel;
    logic             coord_error;

    modport source (output valid, dst_pixel, coord_error, input ready);
    modport sink (input valid, dst_pixel, coord_error, output ready);
endinterface

interface bis_cfg_if;
    import bis_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/bilinear_image_scaler_top.sv]
// ----------------------------------------------------------------------------
// Bilinear image scaler
// Holds an 8-bit source frame and returns bilinear samples of a scaled copy.
// Channels: req (load or sample beats), rsp (one beat per sample), cfg
// (register writes: in_width, in_height, out_width, out_height).
// A load beat writes the frame memory in its accept cycle and gives no beat;
// loads are taken one per cycle while req.ready is high (no sample in flight,
// divider idle). A sample beat runs through the position multiply, neighbour
// clamp, four reads of the single-port frame memory and the blend multiplies
// before rsp.valid. A sample outside the output frame skips to the output state
// and returns with coord_error set. One sample is in flight at a time; req.ready
// can return in the same cycle as the result is posted, so a new sample is
// taken only once the result of the previous one has been posted.
// The scale ratios come from a bit-serial divider that runs after reset and
// after every cfg beat; req.ready is low meanwhile. cfg.ready is always high.
// Reset sets all four registers to 256; the frame content stays unknown
// until loaded. The result waits in an output register while rsp stalls;
// loads are still taken meanwhile, a new sample finishes and then waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bilinear_image_scaler_top_macros.svh"

module bilinear_image_scaler_top #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int FRAC_BITS      = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bis_cfg_if.sink   cfg,
    bis_req_if.sink   req,
    bis_rsp_if.source rsp
);
    import bis_pkg::*;

    localparam int CXW   = $clog2(MAX_SRC_WIDTH);
    localparam int CYW   = $clog2(MAX_SRC_HEIGHT);
    localparam int CW    = (CXW > CYW) ? CXW : CYW;
    localparam int QW    = CW + FRAC_BITS;
    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [IN_SZ_W-1:0] in_width_reg;
    logic [IN_SZ_W-1:0] in_height_reg;
    out_size_t          out_size_reg;
    logic               start_reg;

    logic               cfg_fire;
    logic [CXW-1:0]     em1_x;
    logic [CYW-1:0]     em1_y;
    logic [QW-1:0]      ratio_x;
    logic [QW-1:0]      ratio_y;
    logic               div_busy;
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [PIX_W-1:0]   mem_wdata;
    logic [PIX_W-1:0]   mem_rdata;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg            <= IN_SZ_RESET;
            in_height_reg           <= IN_SZ_RESET;
            out_size_reg.out_width  <= OUT_SZ_RESET;
            out_size_reg.out_height <= OUT_SZ_RESET;
            start_reg               <= 1'b1;
        end
        else
        begin
            start_reg <= cfg_fire;
            if (cfg_fire)
            begin
                unique case (cfg.index)
                    CFG_IN_WIDTH:   in_width_reg            <= IN_SZ_W'(cfg.data);
                    CFG_IN_HEIGHT:  in_height_reg           <= IN_SZ_W'(cfg.data);
                    CFG_OUT_WIDTH:  out_size_reg.out_width  <= OUT_SZ_W'(cfg.data);
                    CFG_OUT_HEIGHT: out_size_reg.out_height <= OUT_SZ_W'(cfg.data);
                    default:        ;
                endcase
            end
        end
    end

    // clamp source sizes to 1..MAX and keep size minus one
    always_comb
    begin
        if (in_width_reg == '0)
            em1_x = '0;
        else if (32'(in_width_reg) > 32'(MAX_SRC_WIDTH))
            em1_x = CXW'(MAX_SRC_WIDTH - 1);
        else
            em1_x = CXW'(32'(in_width_reg) - 32'd1);

        if (in_height_reg == '0)
            em1_y = '0;
        else if (32'(in_height_reg) > 32'(MAX_SRC_HEIGHT))
            em1_y = CYW'(MAX_SRC_HEIGHT - 1);
        else
            em1_y = CYW'(32'(in_height_reg) - 32'd1);
    end

    bis_ratio_div #(
        .QW (QW)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start_reg),
        .dividend_x (QW'({em1_x, {FRAC_BITS{1'b0}}})),
        .dividend_y (QW'({em1_y, {FRAC_BITS{1'b0}}})),
        .out_size   (out_size_reg),
        .ratio_x    (ratio_x),
        .ratio_y    (ratio_y),
        .busy       (div_busy)
    );

    bis_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    bis_core #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .FRAC_BITS      (FRAC_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .ratio_busy (div_busy || start_reg),
        .ratio_x    (ratio_x),
        .ratio_y    (ratio_y),
        .em1_x      (em1_x),
        .em1_y      (em1_y),
        .out_size   (out_size_reg),
        .mem_we     (mem_we),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .mem_rdata  (mem_rdata)
    );

    `BIS_ASSERT_IMP(a_ready_no_div, clk, rst_n, req.ready, !div_busy && !start_reg)
    `BIS_ASSERT_NXT(a_cfg_blocks_req, clk, rst_n, cfg.valid && cfg.ready, !req.ready)
    `BIS_ASSERT_IMP(a_err_zero_pix, clk, rst_n, rsp.valid && rsp.coord_error, rsp.dst_pixel == '0)

endmodule

`default_nettype wire

[design/bis_frame_mem.sv]
// ----------------------------------------------------------------------------
// Bilinear image scaler frame memory
// Single-port source frame store, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_frame_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             addr,
    input  wire logic [bis_pkg::PIX_W-1:0] wdata,
    output logic      [bis_pkg::PIX_W-1:0] rdata
);
    import bis_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/bis_ratio_div.sv]
// ----------------------------------------------------------------------------
// Bilinear image scaler ratio divider
// Restoring divider, one quotient bit a cycle, x axis then y axis.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_ratio_div #(
    parameter  int QW   = 24,
    localparam int CNTW = $clog2(QW)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [QW-1:0]        dividend_x,
    input  wire logic [QW-1:0]        dividend_y,
    input  wire bis_pkg::out_size_t   out_size,
    output logic      [QW-1:0]        ratio_x,
    output logic      [QW-1:0]        ratio_y,
    output logic                      busy
);
    import bis_pkg::*;

    localparam int DW = OUT_SZ_W;

    typedef enum logic {AX_X, AX_Y} axis_t;

    axis_t           axis_reg;
    logic            busy_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [QW-1:0]   quo_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   dvs_reg;
    logic            zero_reg;
    logic [QW-1:0]   ratio_x_reg;
    logic [QW-1:0]   ratio_y_reg;

    logic [DW:0]     shifted;
    logic            ge;
    logic [DW-1:0]   rem_step;
    logic [QW-1:0]   quo_step;
    logic            last;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[QW-1]};
        ge       = shifted >= {1'b0, dvs_reg};
        rem_step = ge ? DW'(shifted - {1'b0, dvs_reg}) : DW'(shifted);
        quo_step = {quo_reg[QW-2:0], ge};
        last     = cnt_reg == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            axis_reg <= AX_X;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            axis_reg <= AX_X;
            cnt_reg  <= CNTW'(QW - 1);
        end
        else if (busy_reg)
        begin
            if (last)
            begin
                if (axis_reg == AX_X)
                begin
                    axis_reg <= AX_Y;
                    cnt_reg  <= CNTW'(QW - 1);
                end
                else
                begin
                    busy_reg <= 1'b0;
                end
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend_x;
            rem_reg  <= '0;
            dvs_reg  <= DW'(out_size.out_width - 1'b1);
            zero_reg <= out_size.out_width < OUT_SZ_W'(2);
        end
        else if (busy_reg)
        begin
            if (last)
            begin
                if (axis_reg == AX_X)
                begin
                    ratio_x_reg <= zero_reg ? '0 : quo_step;
                    quo_reg     <= dividend_y;
                    rem_reg     <= '0;
                    dvs_reg     <= DW'(out_size.out_height - 1'b1);
                    zero_reg    <= out_size.out_height < OUT_SZ_W'(2);
                end
                else
                begin
                    ratio_y_reg <= zero_reg ? '0 : quo_step;
                end
            end
            else
            begin
                quo_reg <= quo_step;
                rem_reg <= rem_step;
            end
        end
    end

    assign ratio_x = ratio_x_reg;
    assign ratio_y = ratio_y_reg;
    assign busy    = busy_reg;

endmodule

`default_nettype wire

[design/bis_core.sv]
// ----------------------------------------------------------------------------
// Bilinear image scaler core
// Request sequencer: frame loads, neighbour reads and the two-axis blend.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_core #(
    parameter  int MAX_SRC_WIDTH  = 256,
    parameter  int MAX_SRC_HEIGHT = 256,
    parameter  int FRAC_BITS      = 16,
    localparam int CXW = $clog2(MAX_SRC_WIDTH),
    localparam int CYW = $clog2(MAX_SRC_HEIGHT),
    localparam int CW  = (CXW > CYW) ? CXW : CYW,
    localparam int QW  = CW + FRAC_BITS,
    localparam int AW  = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    bis_req_if.sink                        req,
    bis_rsp_if.source                      rsp,
    input  wire logic                      ratio_busy,
    input  wire logic [QW-1:0]             ratio_x,
    input  wire logic [QW-1:0]             ratio_y,
    input  wire logic [CXW-1:0]            em1_x,
    input  wire logic [CYW-1:0]            em1_y,
    input  wire bis_pkg::out_size_t        out_size,
    output logic                           mem_we,
    output logic      [AW-1:0]             mem_addr,
    output logic      [bis_pkg::PIX_W-1:0] mem_wdata,
    input  wire logic [bis_pkg::PIX_W-1:0] mem_rdata
);
    import bis_pkg::*;

    localparam int PW = QW + DST_COORD_W;
    localparam int IW = PW - FRAC_BITS;
    localparam int MW = FRAC_BITS + PIX_W + 1;
    localparam int SW = 2 * FRAC_BITS + PIX_W + 2;
    localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_POS, S_NBR, S_RD00, S_RD01, S_RD10, S_RD11, S_LERP, S_SUM, S_OUT
    } state_t;

    state_t           state_reg;
    logic             rsp_valid_reg;
    logic [PIX_W-1:0] rsp_pix_reg;
    logic             rsp_err_reg;

    logic [DST_COORD_W-1:0] dr_reg;
    logic [DST_COORD_W-1:0] dc_reg;
    logic [PW-1:0]          posx_reg;
    logic [PW-1:0]          posy_reg;
    logic [CW-1:0]          xl_reg;
    logic [CW-1:0]          xh_reg;
    logic [CW-1:0]          yl_reg;
    logic [CW-1:0]          yh_reg;
    logic [FRAC_BITS-1:0]   wx_reg;
    logic [FRAC_BITS-1:0]   wy_reg;
    logic [MW-1:0]          mul_reg;
    logic [MW-1:0]          top_reg;
    logic [MW-1:0]          bot_reg;
    logic [SW-1:0]          topw_reg;
    logic [PIX_W-1:0]       res_pix_reg;
    logic                   res_err_reg;

    logic             req_fire;
    logic             is_load;
    logic             load_ok;
    logic             coord_bad;
    logic             out_free;
    logic [31:0]      row_sel;
    logic [31:0]      col_sel;
    logic [IW-1:0]    ix;
    logic [IW-1:0]    iy;
    logic [IW:0]      ixh;
    logic [IW:0]      iyh;
    logic [CW-1:0]    xl_next;
    logic [CW-1:0]    xh_next;
    logic [CW-1:0]    yl_next;
    logic [CW-1:0]    yh_next;
    logic [FRAC_BITS:0] one_wx;
    logic [FRAC_BITS:0] one_wy;
    logic [SW-1:0]    sum;

    assign req.ready = (state_reg == S_IDLE) && !ratio_busy;
    assign req_fire  = req.valid && req.ready;
    assign is_load   = req.req_type == REQ_LOAD;
    assign load_ok   = (32'(req.src_row) < 32'(MAX_SRC_HEIGHT))
                    && (32'(req.src_col) < 32'(MAX_SRC_WIDTH));
    assign coord_bad = ({1'b0, req.dst_row} >= out_size.out_height)
                    || ({1'b0, req.dst_col} >= out_size.out_width);
    assign out_free  = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        ix  = posx_reg[PW-1:FRAC_BITS];
        iy  = posy_reg[PW-1:FRAC_BITS];
        ixh = (IW + 1)'(ix) + (IW + 1)'(posx_reg[FRAC_BITS-1:0] != '0);
        iyh = (IW + 1)'(iy) + (IW + 1)'(posy_reg[FRAC_BITS-1:0] != '0);
        xl_next = (ix > IW'(em1_x)) ? CW'(em1_x) : CW'(ix);
        xh_next = (ixh > (IW + 1)'(em1_x)) ? CW'(em1_x) : CW'(ixh);
        yl_next = (iy > IW'(em1_y)) ? CW'(em1_y) : CW'(iy);
        yh_next = (iyh > (IW + 1)'(em1_y)) ? CW'(em1_y) : CW'(iyh);
        one_wx  = FRAC_ONE - {1'b0, wx_reg};
        one_wy  = FRAC_ONE - {1'b0, wy_reg};
        sum     = topw_reg + SW'(bot_reg) * SW'(wy_reg);
    end

    always_comb
    begin
        unique case (state_reg)
            S_RD00:
            begin
                row_sel = 32'(yl_reg);
                col_sel = 32'(xl_reg);
            end
            S_RD01:
            begin
                row_sel = 32'(yl_reg);
                col_sel = 32'(xh_reg);
            end
            S_RD10:
            begin
                row_sel = 32'(yh_reg);
                col_sel = 32'(xl_reg);
            end
            S_RD11:
            begin
                row_sel = 32'(yh_reg);
                col_sel = 32'(xh_reg);
            end
            default:
            begin
                row_sel = 32'(req.src_row);
                col_sel = 32'(req.src_col);
            end
        endcase
    end

    assign mem_addr  = AW'(row_sel * 32'(MAX_SRC_WIDTH) + col_sel);
    assign mem_we    = req_fire && is_load && load_ok;
    assign mem_wdata = req.src_pixel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_pix_reg   <= '0;
            rsp_err_reg   <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready && (state_reg != S_OUT))
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire && !is_load)
                    begin
                        state_reg <= coord_bad ? S_OUT : S_POS;
                    end
                end
                S_POS:  state_reg <= S_NBR;
                S_NBR:  state_reg <= S_RD00;
                S_RD00: state_reg <= S_RD01;
                S_RD01: state_reg <= S_RD10;
                S_RD10: state_reg <= S_RD11;
                S_RD11: state_reg <= S_LERP;
                S_LERP: state_reg <= S_SUM;
                S_SUM:  state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_pix_reg   <= res_pix_reg;
                        rsp_err_reg   <= res_err_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                dr_reg      <= req.dst_row;
                dc_reg      <= req.dst_col;
                res_pix_reg <= '0;
                res_err_reg <= 1'b1;
            end
            S_POS:
            begin
                posx_reg <= PW'(ratio_x) * PW'(dc_reg);
                posy_reg <= PW'(ratio_y) * PW'(dr_reg);
            end
            S_NBR:
            begin
                xl_reg <= xl_next;
                xh_reg <= xh_next;
                yl_reg <= yl_next;
                yh_reg <= yh_next;
                wx_reg <= posx_reg[FRAC_BITS-1:0];
                wy_reg <= posy_reg[FRAC_BITS-1:0];
            end
            S_RD01:
            begin
                mul_reg <= MW'(mem_rdata) * MW'(one_wx);
            end
            S_RD10:
            begin
                top_reg <= mul_reg + MW'(mem_rdata) * MW'(wx_reg);
            end
            S_RD11:
            begin
                mul_reg  <= MW'(mem_rdata) * MW'(one_wx);
                topw_reg <= SW'(top_reg) * SW'(one_wy);
            end
            S_LERP:
            begin
                bot_reg <= mul_reg + MW'(mem_rdata) * MW'(wx_reg);
            end
            S_SUM:
            begin
                res_pix_reg <= sum[2*FRAC_BITS +: PIX_W];
                res_err_reg <= 1'b0;
            end
            default:
            begin
                res_pix_reg <= res_pix_reg;
            end
        endcase
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.dst_pixel   = rsp_pix_reg;
    assign rsp.coord_error = rsp_err_reg;

endmodule

`default_nettype wire

[verif/tb_bilinear_image_scaler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear image scaler testbench
// Loads source pixels and asks for samples of the scaled frame under several
// size settings, extremes and out-of-range sizes among them. A scoreboard
// keeps its own copy of the frame and the sizes, predicts each sample in
// fixed point and compares every rsp beat field by field. Neighbours of a
// sample are always loaded before the sample goes out.
// ----------------------------------------------------------------------------
import bis_pkg::*;

typedef struct packed {
    logic                   req_type;
    logic [SRC_COORD_W-1:0] src_row;
    logic [SRC_COORD_W-1:0] src_col;
    logic [PIX_W-1:0]       src_pixel;
    logic [DST_COORD_W-1:0] dst_row;
    logic [DST_COORD_W-1:0] dst_col;
} scaler_req_t;

typedef struct packed {
    logic [PIX_W-1:0] dst_pixel;
    logic             coord_error;
} scaler_rsp_t;

class scaler_scoreboard;
    localparam int SRC_W = 256;
    localparam int SRC_H = 256;
    localparam int FRAC  = 16;
    localparam longint unsigned UNIT = 64'd1 << FRAC;

    logic [IN_SZ_W-1:0]  in_width;
    logic [IN_SZ_W-1:0]  in_height;
    logic [OUT_SZ_W-1:0] out_width;
    logic [OUT_SZ_W-1:0] out_height;
    bit [PIX_W-1:0]      frame  [SRC_W*SRC_H];
    bit                  loaded [SRC_W*SRC_H];
    scaler_rsp_t         expected_pixels [$];
    int unsigned         errors;

    function new();
        in_width   = IN_SZ_RESET;
        in_height  = IN_SZ_RESET;
        out_width  = OUT_SZ_RESET;
        out_height = OUT_SZ_RESET;
        errors     = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_IN_WIDTH:   in_width   = data[IN_SZ_W-1:0];
            CFG_IN_HEIGHT:  in_height  = data[IN_SZ_W-1:0];
            CFG_OUT_WIDTH:  out_width  = data[OUT_SZ_W-1:0];
            CFG_OUT_HEIGHT: out_height = data[OUT_SZ_W-1:0];
            default: ;
        endcase
    endfunction

    function longint unsigned eff_size(input longint unsigned sz, input longint unsigned lim);
        if (sz == 0)
            return 1;
        return (sz > lim) ? lim : sz;
    endfunction

    function longint unsigned src_pos(input longint unsigned in_sz,
                                      input longint unsigned out_sz,
                                      input longint unsigned idx);
        longint unsigned ratio;
        ratio = (out_sz >= 2) ? ((in_sz - 1) << FRAC) / (out_sz - 1) : 0;
        return ratio * idx;
    endfunction

    function bit in_frame(input logic [DST_COORD_W-1:0] row, input logic [DST_COORD_W-1:0] col);
        return (row < out_height) && (col < out_width);
    endfunction

    function void neighbours(input logic [DST_COORD_W-1:0] row,
                             input logic [DST_COORD_W-1:0] col,
                             output int unsigned addr [4],
                             output longint unsigned wx,
                             output longint unsigned wy);
        longint unsigned iw, ih, px, py, xl, xh, yl, yh;
        iw = eff_size(in_width, SRC_W);
        ih = eff_size(in_height, SRC_H);
        px = src_pos(iw, out_width, col);
        py = src_pos(ih, out_height, row);
        xl = px >> FRAC;
        yl = py >> FRAC;
        wx = px & (UNIT - 1);
        wy = py & (UNIT - 1);
        xh = xl + (wx != 0);
        yh = yl + (wy != 0);
        if (xl > iw - 1) xl = iw - 1;
        if (xh > iw - 1) xh = iw - 1;
        if (yl > ih - 1) yl = ih - 1;
        if (yh > ih - 1) yh = ih - 1;
        addr[0] = 32'(yl * SRC_W + xl);
        addr[1] = 32'(yl * SRC_W + xh);
        addr[2] = 32'(yh * SRC_W + xl);
        addr[3] = 32'(yh * SRC_W + xh);
    endfunction

    function logic [PIX_W-1:0] blend_pixel(input logic [DST_COORD_W-1:0] row,
                                           input logic [DST_COORD_W-1:0] col);
        int unsigned     addr [4];
        longint unsigned wx, wy, sum;
        neighbours(row, col, addr, wx, wy);
        sum = frame[addr[0]] * (UNIT - wx) * (UNIT - wy)
            + frame[addr[1]] * wx * (UNIT - wy)
            + frame[addr[2]] * (UNIT - wx) * wy
            + frame[addr[3]] * wx * wy;
        sum = sum >> (2 * FRAC);
        if (sum > 255)
            sum = 255;
        return sum[PIX_W-1:0];
    endfunction

    function bit find_unloaded(input logic [DST_COORD_W-1:0] row,
                               input logic [DST_COORD_W-1:0] col,
                               output int unsigned addr);
        int unsigned     nb [4];
        longint unsigned wx, wy;
        addr = 0;
        if (!in_frame(row, col))
            return 0;
        neighbours(row, col, nb, wx, wy);
        foreach (nb[i])
        begin
            if (!loaded[nb[i]])
            begin
                addr = nb[i];
                return 1;
            end
        end
        return 0;
    endfunction

    function void note_request(input scaler_req_t item);
        int unsigned a;
        scaler_rsp_t want;
        if (item.req_type == REQ_LOAD)
        begin
            a = item.src_row * SRC_W + item.src_col;
            frame[a]  = item.src_pixel;
            loaded[a] = 1'b1;
        end
        else
        begin
            if (in_frame(item.dst_row, item.dst_col))
            begin
                want.dst_pixel   = blend_pixel(item.dst_row, item.dst_col);
                want.coord_error = 1'b0;
            end
            else
            begin
                want.dst_pixel   = '0;
                want.coord_error = 1'b1;
            end
            expected_pixels.push_back(want);
        end
    endfunction

    function void check_pixel(input logic [PIX_W-1:0] pixel, input logic coord_error);
        scaler_rsp_t want;
        if (expected_pixels.size() == 0)
        begin
            $error("rsp beat with no sample outstanding: dst_pixel %0d coord_error %0d",
                   pixel, coord_error);
            errors++;
            return;
        end
        want = expected_pixels.pop_front();
        if (pixel !== want.dst_pixel)
        begin
            $error("dst_pixel: expected %0d, actual %0d", want.dst_pixel, pixel);
            errors++;
        end
        if (coord_error !== want.coord_error)
        begin
            $error("coord_error: expected %0d, actual %0d", want.coord_error, coord_error);
            errors++;
        end
    endfunction

    function int unsigned pending();
        return expected_pixels.size();
    endfunction
endclass

module tb_bilinear_image_scaler_top;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PHASE_ITEMS    = 55;
    localparam int RANDOM_PHASES  = 12;
    localparam int MAX_SRC_W      = 256;
    localparam int MAX_SRC_H      = 256;
    localparam int FRAC_W         = 16;

    logic        clk;
    logic        rst_n;
    bit          steady = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned sent_items = 0;

    logic [CFG_DATA_W-1:0] fixed_sizes [8][4] = '{
        '{11'd1,   11'd1,   11'd2,    11'd2},
        '{11'd256, 11'd256, 11'd1024, 11'd1024},
        '{11'd256, 11'd2,   11'd1024, 11'd3},
        '{11'd2,   11'd256, 11'd3,    11'd1024},
        '{11'd5,   11'd7,   11'd13,   11'd9},
        '{11'd200, 11'd150, 11'd40,   11'd30},
        '{11'd256, 11'd256, 11'd2,    11'd2},
        '{11'd3,   11'd3,   11'd1024, 11'd1024}
    };

    scaler_scoreboard sb = new();

    bis_cfg_if cfg ();
    bis_req_if req ();
    bis_rsp_if rsp ();

    bilinear_image_scaler_top #(
        .MAX_SRC_WIDTH  (MAX_SRC_W),
        .MAX_SRC_HEIGHT (MAX_SRC_H),
        .FRAC_BITS      (FRAC_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
            sb.check_pixel(rsp.dst_pixel, rsp.coord_error);
        rsp.ready <= steady || ($urandom_range(99) >= 20);
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("FAIL bilinear_image_scaler_top");
        $finish;
    end

    task automatic send_item(input scaler_req_t item);
        if (!steady && $urandom_range(99) < 15)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.req_type  <= item.req_type;
        req.src_row   <= item.src_row;
        req.src_col   <= item.src_col;
        req.src_pixel <= item.src_pixel;
        req.dst_row   <= item.dst_row;
        req.dst_col   <= item.dst_col;
        do
            @(posedge clk);
        while (!(req.valid && req.ready));
        sb.note_request(item);
        sent_items++;
    endtask

    task automatic load_pixel(input int unsigned row, input int unsigned col,
                              input int unsigned pixel);
        scaler_req_t item;
        item.req_type  = REQ_LOAD;
        item.src_row   = SRC_COORD_W'(row);
        item.src_col   = SRC_COORD_W'(col);
        item.src_pixel = PIX_W'(pixel);
        item.dst_row   = DST_COORD_W'($urandom);
        item.dst_col   = DST_COORD_W'($urandom);
        send_item(item);
    endtask

    task automatic sample_pixel(input int unsigned row, input int unsigned col);
        scaler_req_t item;
        int unsigned addr;
        while (sb.find_unloaded(DST_COORD_W'(row), DST_COORD_W'(col), addr))
            load_pixel(addr / MAX_SRC_W, addr % MAX_SRC_W, $urandom_range(0, 255));
        item.req_type  = REQ_SAMPLE;
        item.src_row   = SRC_COORD_W'($urandom);
        item.src_col   = SRC_COORD_W'($urandom);
        item.src_pixel = PIX_W'($urandom);
        item.dst_row   = DST_COORD_W'(row);
        item.dst_col   = DST_COORD_W'(col);
        send_item(item);
    endtask

    task automatic sample_outside();
        int unsigned row, col;
        row = $urandom_range(0, 1023);
        col = $urandom_range(0, 1023);
        if (sb.out_height <= 1023 && (sb.out_width > 1023 || $urandom_range(1) == 1))
            row = $urandom_range(32'(sb.out_height), 1023);
        else if (sb.out_width <= 1023)
            col = $urandom_range(32'(sb.out_width), 1023);
        sample_pixel(row, col);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_DATA_W-1:0] iw, input logic [CFG_DATA_W-1:0] ih,
                                input logic [CFG_DATA_W-1:0] ow, input logic [CFG_DATA_W-1:0] oh);
        logic [CFG_IDX_W-1:0]  regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{CFG_IN_WIDTH, CFG_IN_HEIGHT, CFG_OUT_WIDTH, CFG_OUT_HEIGHT};
        vals = '{iw, ih, ow, oh};
        for (int i = 0; i < 4; i++)
        begin
            cfg.valid <= 1'b1;
            cfg.index <= regs[i];
            cfg.data  <= vals[i];
            do
                @(posedge clk);
            while (!(cfg.valid && cfg.ready));
            sb.set_reg(regs[i], vals[i]);
        end
        cfg.valid <= 1'b0;
    endtask

    function automatic int unsigned last_index(input logic [OUT_SZ_W-1:0] sz);
        return (sz > 1024) ? 1023 : 32'(sz) - 1;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size(input int unsigned lo,
                                                        input int unsigned hi_small,
                                                        input int unsigned hi_big);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return CFG_DATA_W'($urandom_range(0, 2047));
        if (r < 80)
            return CFG_DATA_W'($urandom_range(lo, hi_small));
        return CFG_DATA_W'($urandom_range(lo, hi_big));
    endfunction

    task automatic run_phase(input int unsigned items);
        longint unsigned iw, ih;
        int unsigned     pick;
        int unsigned     first;
        iw = sb.eff_size(sb.in_width, MAX_SRC_W);
        ih = sb.eff_size(sb.in_height, MAX_SRC_H);
        first = sent_items;
        while (sent_items - first < items)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                load_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255));
            else if (pick < 30)
                load_pixel($urandom_range(0, 32'(ih - 1)), $urandom_range(0, 32'(iw - 1)),
                           $urandom_range(0, 255));
            else if (pick < 40 || sb.out_width == 0 || sb.out_height == 0)
                sample_outside();
            else
                sample_pixel($urandom_range(0, last_index(sb.out_height)),
                             $urandom_range(0, last_index(sb.out_width)));
        end
        drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg.valid     = 1'b0;
        cfg.index     = CFG_IN_WIDTH;
        cfg.data      = '0;
        req.valid     = 1'b0;
        req.req_type  = REQ_LOAD;
        req.src_row   = '0;
        req.src_col   = '0;
        req.src_pixel = '0;
        req.dst_row   = '0;
        req.dst_col   = '0;
        rsp.ready     = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset sizes map one to one: corners, a mid pixel, then coordinates past the frame
        load_pixel(0, 0, 8'h00);
        load_pixel(0, 255, 8'hA5);
        load_pixel(255, 0, 8'h5A);
        load_pixel(255, 255, 8'hFF);
        load_pixel(128, 127, 8'h80);
        sample_pixel(0, 0);
        sample_pixel(0, 255);
        sample_pixel(255, 0);
        sample_pixel(255, 255);
        sample_pixel(128, 127);
        sample_pixel(256, 0);
        sample_pixel(0, 256);
        sample_pixel(1023, 1023);
        drain();

        // zero source size acts as one
        write_config(11'd0, 11'd0, 11'd2, 11'd2);
        sample_pixel(0, 0);
        sample_pixel(1, 1);
        sample_pixel(2, 1);
        drain();

        // oversized source clamps to the store; output size one gives a zero ratio
        write_config(11'h7FF, 11'd300, 11'd1, 11'd1);
        sample_pixel(0, 0);
        sample_pixel(0, 1);
        sample_pixel(1, 0);
        drain();

        // output width zero rejects every sample
        write_config(11'd256, 11'd256, 11'd0, 11'h7FF);
        sample_pixel(0, 0);
        sample_pixel(1023, 0);
        drain();

        write_config(11'd2, 11'd2, 11'd1024, 11'd1024);
        sample_pixel(1023, 1023);
        sample_pixel(511, 512);
        drain();

        foreach (fixed_sizes[p])
        begin
            steady = (p == 4);
            write_config(fixed_sizes[p][0], fixed_sizes[p][1],
                         fixed_sizes[p][2], fixed_sizes[p][3]);
            run_phase(PHASE_ITEMS);
        end
        steady = 1'b0;

        repeat (RANDOM_PHASES)
        begin
            write_config(pick_size(1, 16, 256), pick_size(1, 16, 256),
                         pick_size(2, 40, 1024), pick_size(2, 40, 1024));
            run_phase(PHASE_ITEMS);
        end

        if (sb.errors == 0)
            $display("PASS bilinear_image_scaler_top");
        else
            $display("FAIL bilinear_image_scaler_top");
        $finish;
    end
endmodule
